/* design/kwhm_pkg.sv */
// ----------------------------------------------------------------------------
// kwhm_pkg: shared constants and types for the k-way heap merge engine
// Holds field widths, the default way count, request modes and the sift
// compare result.
// ----------------------------------------------------------------------------
package kwhm_pkg;

    // Default number of merge ways (heap depth)
    localparam int MAX_WAYS_DEF = 32;

    // Fixed field widths
    localparam int VALUE_W  = 64;
    localparam int SOURCE_W = 5;
    localparam int CFG_W    = 6;

    // Request modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_REFILL = 1'b1;

    // Outcome of one sift level: move a child up, and which one
    typedef struct packed {
        logic swap;
        logic take_hi;
    } sel_t;

endpackage

/* design/kwhm_ram.sv */
// ----------------------------------------------------------------------------
// kwhm_ram: generic synchronous RAM, one write port, two read ports
// Read data is registered: it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module kwhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register both read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* design/kwhm_node_cmp.sv */
// ----------------------------------------------------------------------------
// kwhm_node_cmp: one sift-down level of the min-heap
// Picks the smallest of a node and its two children; exhausted entries order
// after every live one and a child moves up only when strictly smaller.
// ----------------------------------------------------------------------------
module kwhm_node_cmp (
    input  logic [kwhm_pkg::VALUE_W-1:0] cur_val,
    input  logic                         cur_dead,
    input  logic [kwhm_pkg::VALUE_W-1:0] lo_val,
    input  logic                         lo_dead,
    input  logic                         lo_ok,
    input  logic [kwhm_pkg::VALUE_W-1:0] hi_val,
    input  logic                         hi_dead,
    input  logic                         hi_ok,
    output kwhm_pkg::sel_t               sel
);

    logic lo_lt_cur;
    logic hi_lt_cur;
    logic hi_lt_lo;
    logic lo_wins;
    logic hi_wins;

    // Compare all pairs in parallel
    assign lo_lt_cur = !lo_dead && (cur_dead || (lo_val < cur_val));
    assign hi_lt_cur = !hi_dead && (cur_dead || (hi_val < cur_val));
    assign hi_lt_lo  = !hi_dead && (lo_dead  || (hi_val < lo_val));

    // Resolve the winner: low child first, then high child against the best
    assign lo_wins = lo_ok && lo_lt_cur;
    assign hi_wins = hi_ok && (lo_wins ? hi_lt_lo : hi_lt_cur);

    assign sel.swap    = lo_wins || hi_wins;
    assign sel.take_hi = hi_wins;

endmodule

/* design/kway_heap_merge.sv */
// ----------------------------------------------------------------------------
// kway_heap_merge: k-way merge of sorted streams through a min-heap
// Loads stream heads, builds a heap in RAM, then emits the minimum after the
// build and each refill of the stream last emitted, done when all run dry.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   ------------------------  -------------------------------
//  cfg       cfg_wr_en                 cfg_wr_data (num_streams)
//  in        in_valid / in_stall       mode, value, exhausted
//  out       out_valid / out_stall     min_value, source, done_res
//
//  A load request that does not end loading gives no result. Ending a load
//  with n heads reads and loads each node from (n-1)/2 down to the root and
//  sifts it level by level, then emits (just the emit when n is 0). A refill
//  is accepted, sifted from the root level by level and emitted; a refill that
//  exhausts the last stream is accepted and then emits a done result.
//  Reset clears control state only; emit holds while a result waits on a stall.
//
module kway_heap_merge #(
    parameter int MAX_WAYS = kwhm_pkg::MAX_WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kwhm_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [kwhm_pkg::VALUE_W-1:0]  value,
    input  logic                          exhausted,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kwhm_pkg::VALUE_W-1:0]  min_value,
    output logic [kwhm_pkg::SOURCE_W-1:0] source,
    output logic                          done_res
);

    localparam int IDX_W   = $clog2(MAX_WAYS);
    localparam int CNT_W   = $clog2(MAX_WAYS + 1);
    localparam int CHILD_W = IDX_W + 2;
    localparam int VAL_W   = kwhm_pkg::VALUE_W;
    localparam int SRC_W   = kwhm_pkg::SOURCE_W;
    localparam int CFG_W   = kwhm_pkg::CFG_W;
    localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_W   = 1 + IDX_W + VAL_W;

    typedef struct packed {
        logic             dead;
        logic [IDX_W-1:0] src;
        logic [VAL_W-1:0] val;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_BLD_RD = 5'b00010,
        S_BLD_LD = 5'b00100,
        S_SIFT   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     heap_cnt_reg, heap_cnt_next;
    logic [CNT_W-1:0]     dead_cnt_reg, dead_cnt_next;
    logic                 merging_reg, merging_next;
    logic [CFG_W-1:0]     num_streams_reg, num_streams_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 emit_done_reg, emit_done_next;
    entry_t               cur_reg, cur_next;
    entry_t               root_reg, root_next;
    logic [IDX_W-1:0]     at_reg, at_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [VAL_W-1:0]     min_value_reg, min_value_next;
    logic [SRC_W-1:0]     source_reg, source_next;
    logic                 done_res_reg, done_res_next;

    logic                 in_acc;
    logic [LIM_W-1:0]     lim_wide;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     dead_inc;
    logic [IDX_W-1:0]     at_issue;
    logic [CHILD_W-1:0]   issue_lo;
    logic [CHILD_W-1:0]   issue_hi;
    logic [CHILD_W-1:0]   lo_idx;
    logic [CHILD_W-1:0]   hi_idx;
    logic                 lo_ok;
    logic                 hi_ok;
    logic [IDX_W-1:0]     best_idx;
    entry_t               best_ent;
    entry_t               ent_a;
    entry_t               ent_b;
    entry_t               new_root;
    kwhm_pkg::sel_t       sel;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic [IDX_W-1:0]     rd_addr_a;
    logic [IDX_W-1:0]     rd_addr_b;
    logic [ENT_W-1:0]     rd_data_a;
    logic [ENT_W-1:0]     rd_data_b;

    // Heap storage: one entry per way
    kwhm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WAYS)
    ) u_heap_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign ent_a = rd_data_a;
    assign ent_b = rd_data_b;

    // Children of the node under sift and their presence in the heap
    assign lo_idx = CHILD_W'({at_reg, 1'b1});
    assign hi_idx = lo_idx + CHILD_W'(1);
    assign lo_ok  = lo_idx < CHILD_W'(heap_cnt_reg);
    assign hi_ok  = hi_idx < CHILD_W'(heap_cnt_reg);

    // One heap level per cycle
    kwhm_node_cmp u_node_cmp (
        .cur_val  (cur_reg.val),
        .cur_dead (cur_reg.dead),
        .lo_val   (ent_a.val),
        .lo_dead  (ent_a.dead),
        .lo_ok    (lo_ok),
        .hi_val   (ent_b.val),
        .hi_dead  (ent_b.dead),
        .hi_ok    (hi_ok),
        .sel      (sel)
    );

    assign best_idx = sel.take_hi ? hi_idx[IDX_W-1:0] : lo_idx[IDX_W-1:0];
    assign best_ent = sel.take_hi ? ent_b : ent_a;

    // Clamp the stream count to 1..MAX_WAYS
    always_comb
    begin
        lim_wide = LIM_W'(num_streams_reg);
        if (lim_wide == '0)
        begin
            lim_wide = LIM_W'(1);
        end
        else if (lim_wide > LIM_W'(MAX_WAYS))
        begin
            lim_wide = LIM_W'(MAX_WAYS);
        end
        limit = lim_wide[CNT_W-1:0];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cnt_inc   = heap_cnt_reg + CNT_W'(1);
    assign dead_inc  = dead_cnt_reg + CNT_W'(!root_reg.dead);

    // Refilled root: new value or the exhausted mark
    always_comb
    begin
        new_root = root_reg;
        if (exhausted)
        begin
            new_root.dead = 1'b1;
        end
        else
        begin
            new_root.val = value;
        end
    end

    // Issue child reads for the node that sifts next cycle
    assign issue_lo  = CHILD_W'({at_issue, 1'b1});
    assign issue_hi  = issue_lo + CHILD_W'(1);
    assign rd_addr_a = (state_reg == S_BLD_RD) ? k_reg : issue_lo[IDX_W-1:0];
    assign rd_addr_b = issue_hi[IDX_W-1:0];

    // Sequencer: load, build, sift and emit
    always_comb
    begin
        state_next       = state_reg;
        heap_cnt_next    = heap_cnt_reg;
        dead_cnt_next    = dead_cnt_reg;
        merging_next     = merging_reg;
        num_streams_next = cfg_wr_en ? cfg_wr_data : num_streams_reg;
        out_valid_next   = out_valid_reg && out_stall;
        emit_done_next   = emit_done_reg;
        cur_next         = cur_reg;
        root_next        = root_reg;
        at_next          = at_reg;
        k_next           = k_reg;
        min_value_next   = min_value_reg;
        source_next      = source_reg;
        done_res_next    = done_res_reg;
        at_issue         = at_reg;
        wr_en            = 1'b0;
        wr_addr          = at_reg;
        wr_data          = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                at_issue = '0;
                if (in_acc && !merging_reg && (mode == kwhm_pkg::MODE_LOAD))
                begin
                    if (!exhausted && (heap_cnt_reg < limit))
                    begin
                        // Store the next stream head
                        wr_en         = 1'b1;
                        wr_addr       = heap_cnt_reg[IDX_W-1:0];
                        wr_data       = {1'b0, heap_cnt_reg[IDX_W-1:0], value};
                        heap_cnt_next = cnt_inc;
                        if (cnt_inc >= limit)
                        begin
                            k_next     = IDX_W'((cnt_inc - CNT_W'(1)) >> 1);
                            state_next = S_BLD_RD;
                        end
                    end
                    else if (heap_cnt_reg == '0)
                    begin
                        // Nothing loaded: report done at once
                        emit_done_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        k_next     = IDX_W'((heap_cnt_reg - CNT_W'(1)) >> 1);
                        state_next = S_BLD_RD;
                    end
                end
                else if (in_acc && merging_reg && (mode == kwhm_pkg::MODE_REFILL))
                begin
                    if (exhausted)
                    begin
                        dead_cnt_next = dead_inc;
                    end
                    if (exhausted && (dead_inc >= heap_cnt_reg))
                    begin
                        // Last live stream ran dry: drop the heap
                        heap_cnt_next  = '0;
                        dead_cnt_next  = '0;
                        merging_next   = 1'b0;
                        emit_done_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        cur_next       = new_root;
                        at_next        = '0;
                        emit_done_next = 1'b0;
                        state_next     = S_SIFT;
                    end
                end
            end

            S_BLD_RD:
            begin
                state_next = S_BLD_LD;
            end

            S_BLD_LD:
            begin
                cur_next       = ent_a;
                at_issue       = k_reg;
                at_next        = k_reg;
                emit_done_next = 1'b0;
                state_next     = S_SIFT;
            end

            S_SIFT:
            begin
                wr_en = 1'b1;
                if (sel.swap)
                begin
                    // Move the smaller child up and descend
                    wr_data = best_ent;
                    if (at_reg == '0)
                    begin
                        root_next = best_ent;
                    end
                    at_issue = best_idx;
                    at_next  = best_idx;
                end
                else
                begin
                    // Settle the sifting entry here
                    if (at_reg == '0)
                    begin
                        root_next = cur_reg;
                    end
                    if (merging_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (k_reg == '0)
                    begin
                        merging_next = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        k_next     = k_reg - IDX_W'(1);
                        state_next = S_BLD_RD;
                    end
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    done_res_next  = emit_done_reg;
                    min_value_next = emit_done_reg ? '0 : root_reg.val;
                    source_next    = emit_done_reg ? '0 : SRC_W'(root_reg.src);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            heap_cnt_reg    <= '0;
            dead_cnt_reg    <= '0;
            merging_reg     <= 1'b0;
            num_streams_reg <= CFG_W'(32);
            out_valid_reg   <= 1'b0;
            emit_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            heap_cnt_reg    <= heap_cnt_next;
            dead_cnt_reg    <= dead_cnt_next;
            merging_reg     <= merging_next;
            num_streams_reg <= num_streams_next;
            out_valid_reg   <= out_valid_next;
            emit_done_reg   <= emit_done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        root_reg      <= root_next;
        at_reg        <= at_next;
        k_reg         <= k_next;
        min_value_reg <= min_value_next;
        source_reg    <= source_next;
        done_res_reg  <= done_res_next;
    end

    assign out_valid = out_valid_reg;
    assign min_value = min_value_reg;
    assign source    = source_reg;
    assign done_res  = done_res_reg;

    // Exhausted streams never outnumber loaded ones
    a_dead_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        dead_cnt_reg <= heap_cnt_reg)
        else $error("dead count above heap count");

    // Heap never grows past its depth
    a_cnt_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        heap_cnt_reg <= CNT_W'(MAX_WAYS))
        else $error("heap count above depth");

    // Merge phase always has a loaded heap
    a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        merging_reg |-> (heap_cnt_reg != '0))
        else $error("merging with empty heap");

    // Sift node stays inside the heap
    a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT) |-> (CNT_W'(at_reg) < heap_cnt_reg))
        else $error("sift node outside heap");

    // A fresh result comes only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

endmodule
